// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset
`define OMVCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included
`define OMVCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/omvct_pkg.sv =====
`timescale 1ns / 1ps

package omvct_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int DUR_WIDTH       = 16;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_PLAY   = 3'd1;
  localparam logic [2:0] OP_STOP   = 3'd2;
  localparam logic [2:0] OP_LOOP   = 3'd3;
  localparam logic [2:0] OP_VOLUME = 3'd4;

  localparam logic [2:0] CFG_ENABLE_PLAY = 3'd0;
  localparam logic [2:0] CFG_START_HIGH  = 3'd1;
  localparam logic [2:0] CFG_START_LOW   = 3'd2;
  localparam logic [2:0] CFG_LONG        = 3'd3;
  localparam logic [2:0] CFG_SHORT       = 3'd4;

  localparam logic [7:0] BYTE_PREFIX   = 8'h0a;
  localparam logic [7:0] BYTE_PLAY_END = 8'h0b;
  localparam logic [7:0] BYTE_STOP     = 8'h13;
  localparam logic [7:0] BYTE_LOOP_END = 8'h0e;
  localparam logic [7:0] BYTE_VOL_END  = 8'h0c;
  localparam logic [7:0] LOOP_SINGLE   = 8'h01;
  localparam logic [7:0] LOOP_OTHER    = 8'h02;
  localparam logic [4:0] VOLUME_MAX    = 5'd30;

  localparam logic [15:0] RST_START_HIGH = 16'd100;
  localparam logic [15:0] RST_START_LOW  = 16'd220;
  localparam logic [15:0] RST_LONG       = 16'd50;
  localparam logic [15:0] RST_SHORT      = 16'd21;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'b00001,
    PH_START_HIGH = 5'b00010,
    PH_START_LOW  = 5'b00100,
    PH_BIT_HIGH   = 5'b01000,
    PH_BIT_LOW    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic                 enable_play;
    logic [DUR_WIDTH-1:0] start_high;
    logic [DUR_WIDTH-1:0] start_low;
    logic [DUR_WIDTH-1:0] long_ticks;
    logic [DUR_WIDTH-1:0] short_ticks;
  } cfg_t;

  typedef struct packed {
    logic            load;
    logic            rejected;
    logic [2:0]      total;
    logic [3:0][7:0] bytes;
  } cmd_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic rejected;
  } res_t;

endpackage

// ===== rtl/core/omvct_cmd.sv =====
`timescale 1ns / 1ps

module omvct_cmd (
  input  logic              [2:0] operation,
  input  logic              [7:0] track,
  input  logic                    loop_single,
  input  logic signed       [7:0] volume,
  input  logic                    enable_play,
  input  logic                    busy,
  output omvct_pkg::cmd_t         cmd
);

  logic [2:0]  op_eff;
  logic        is_cmd;
  logic [15:0] tprod;
  logic [4:0]  tq;
  logic [7:0]  tr8;
  logic [4:0]  vc;
  logic [1:0]  vq;
  logic [4:0]  vr5;

  always_comb begin
    op_eff = operation;
    if (operation == omvct_pkg::OP_PLAY && !enable_play) begin
      op_eff = omvct_pkg::OP_TICK;
    end
  end

  assign is_cmd = (op_eff == omvct_pkg::OP_PLAY) || (op_eff == omvct_pkg::OP_STOP) ||
                  (op_eff == omvct_pkg::OP_LOOP) || (op_eff == omvct_pkg::OP_VOLUME);

  // track / 10 by reciprocal, exact for 8-bit values
  assign tprod = {8'd0, track} * 16'd205;
  assign tq    = tprod[15:11];
  assign tr8   = track - ({3'd0, tq} * 8'd10);

  always_comb begin
    if (volume[7]) begin
      vc = 5'd0;
    end else if (volume > $signed({3'd0, omvct_pkg::VOLUME_MAX})) begin
      vc = omvct_pkg::VOLUME_MAX;
    end else begin
      vc = volume[4:0];
    end
  end

  always_comb begin
    if (vc >= 5'd30) begin
      vq = 2'd3;
    end else if (vc >= 5'd20) begin
      vq = 2'd2;
    end else if (vc >= 5'd10) begin
      vq = 2'd1;
    end else begin
      vq = 2'd0;
    end
  end

  assign vr5 = vc - ({3'd0, vq} * 5'd10);

  always_comb begin
    cmd.load     = is_cmd && !busy;
    cmd.rejected = is_cmd && busy;
    cmd.total    = 3'd0;
    cmd.bytes    = '0;
    unique case (op_eff)
      omvct_pkg::OP_PLAY: begin
        cmd.bytes[0] = omvct_pkg::BYTE_PREFIX;
        if (track >= 8'd10) begin
          cmd.bytes[1] = {3'd0, tq};
          cmd.bytes[2] = {4'd0, tr8[3:0]};
          cmd.bytes[3] = omvct_pkg::BYTE_PLAY_END;
          cmd.total    = 3'd4;
        end else begin
          cmd.bytes[1] = track;
          cmd.bytes[2] = omvct_pkg::BYTE_PLAY_END;
          cmd.total    = 3'd3;
        end
      end
      omvct_pkg::OP_STOP: begin
        cmd.bytes[0] = omvct_pkg::BYTE_STOP;
        cmd.total    = 3'd1;
      end
      omvct_pkg::OP_LOOP: begin
        cmd.bytes[0] = omvct_pkg::BYTE_PREFIX;
        cmd.bytes[1] = loop_single ? omvct_pkg::LOOP_SINGLE : omvct_pkg::LOOP_OTHER;
        cmd.bytes[2] = omvct_pkg::BYTE_LOOP_END;
        cmd.total    = 3'd3;
      end
      omvct_pkg::OP_VOLUME: begin
        cmd.bytes[0] = omvct_pkg::BYTE_PREFIX;
        cmd.bytes[1] = {6'd0, vq};
        cmd.bytes[2] = {3'd0, vr5};
        cmd.bytes[3] = omvct_pkg::BYTE_VOL_END;
        cmd.total    = 3'd4;
      end
      default: begin
        cmd.total = 3'd0;
      end
    endcase
  end

endmodule

// ===== rtl/core/omvct_seq.sv =====
`timescale 1ns / 1ps

module omvct_seq #(
  parameter int TIMER_WIDTH = omvct_pkg::TIMER_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  omvct_pkg::cfg_t   cfg,
  input  omvct_pkg::cmd_t   cmd,
  output logic              busy,
  output logic              line_level,
  output logic              busy_res
);

  localparam logic [32:0] TMAX = (33'd1 << TIMER_WIDTH) - 33'd1;
  localparam logic [TIMER_WIDTH-1:0] TONE = {{(TIMER_WIDTH-1){1'b0}}, 1'b1};

  function automatic logic [TIMER_WIDTH-1:0] dur(input logic [15:0] v);
    logic [32:0] d;
    d = (v == 16'd0) ? 33'd1 : {17'd0, v};
    if (d > TMAX) begin
      dur = TMAX[TIMER_WIDTH-1:0];
    end else begin
      dur = d[TIMER_WIDTH-1:0];
    end
  endfunction

  logic [3:0][7:0]          queue_r;
  omvct_pkg::phase_t        phase_r, phase_nxt, ph0;
  logic [2:0]               total_r, total0;
  logic [1:0]               bytepos_r, bytepos_nxt, bytepos0;
  logic [2:0]               bitpos_r, bitpos_nxt, bitpos0;
  logic [TIMER_WIDTH-1:0]   timer_r, timer_nxt, timer0, tdec;
  logic [7:0]               shift_r, shift_nxt, shift0, shifted;
  logic [1:0]               next_pos;

  assign busy = (phase_r != omvct_pkg::PH_IDLE);

  always_comb begin
    if (cmd.load) begin
      ph0      = omvct_pkg::PH_START_HIGH;
      total0   = cmd.total;
      bytepos0 = 2'd0;
      bitpos0  = 3'd0;
      timer0   = dur(cfg.start_high);
      shift0   = cmd.bytes[0];
    end else begin
      ph0      = phase_r;
      total0   = total_r;
      bytepos0 = bytepos_r;
      bitpos0  = bitpos_r;
      timer0   = timer_r;
      shift0   = shift_r;
    end
  end

  assign line_level = (ph0 == omvct_pkg::PH_IDLE) || (ph0 == omvct_pkg::PH_START_HIGH) ||
                      (ph0 == omvct_pkg::PH_BIT_HIGH);
  assign busy_res   = (ph0 != omvct_pkg::PH_IDLE);
  assign tdec       = (timer0 != '0) ? timer0 - TONE : '0;
  assign shifted    = shift0 >> 1;
  assign next_pos   = bytepos0 + 2'd1;

  always_comb begin
    phase_nxt   = ph0;
    bytepos_nxt = bytepos0;
    bitpos_nxt  = bitpos0;
    timer_nxt   = tdec;
    shift_nxt   = shift0;
    if (ph0 != omvct_pkg::PH_IDLE && tdec == '0) begin
      unique case (ph0)
        omvct_pkg::PH_START_HIGH: begin
          phase_nxt = omvct_pkg::PH_START_LOW;
          timer_nxt = dur(cfg.start_low);
        end
        omvct_pkg::PH_START_LOW: begin
          phase_nxt  = omvct_pkg::PH_BIT_HIGH;
          bitpos_nxt = 3'd0;
          timer_nxt  = dur(shift0[0] ? cfg.long_ticks : cfg.short_ticks);
        end
        omvct_pkg::PH_BIT_HIGH: begin
          phase_nxt = omvct_pkg::PH_BIT_LOW;
          timer_nxt = dur(shift0[0] ? cfg.short_ticks : cfg.long_ticks);
        end
        omvct_pkg::PH_BIT_LOW: begin
          shift_nxt = shifted;
          if (bitpos0 != 3'd7) begin
            bitpos_nxt = bitpos0 + 3'd1;
            phase_nxt  = omvct_pkg::PH_BIT_HIGH;
            timer_nxt  = dur(shifted[0] ? cfg.long_ticks : cfg.short_ticks);
          end else begin
            bitpos_nxt = 3'd0;
            if (({1'b0, bytepos0} + 3'd1) >= total0) begin
              bytepos_nxt = 2'd0;
              phase_nxt   = omvct_pkg::PH_IDLE;
              timer_nxt   = '0;
            end else begin
              bytepos_nxt = next_pos;
              shift_nxt   = queue_r[next_pos];
              phase_nxt   = omvct_pkg::PH_START_HIGH;
              timer_nxt   = dur(cfg.start_high);
            end
          end
        end
        default: begin
          phase_nxt = omvct_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (step && cmd.load) begin
      queue_r <= cmd.bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= omvct_pkg::PH_IDLE;
      total_r   <= 3'd0;
      bytepos_r <= 2'd0;
      bitpos_r  <= 3'd0;
      timer_r   <= '0;
      shift_r   <= 8'd0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      total_r   <= total0;
      bytepos_r <= bytepos_nxt;
      bitpos_r  <= bitpos_nxt;
      timer_r   <= timer_nxt;
      shift_r   <= shift_nxt;
    end
  end

endmodule

// ===== rtl/core/omvct_skid.sv =====
`timescale 1ns / 1ps

module omvct_skid (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  omvct_pkg::res_t in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output omvct_pkg::res_t out_data
);

  logic            out_valid_r, skid_valid_r;
  omvct_pkg::res_t out_data_r, skid_data_r;
  logic            take, out_free;

  assign in_stall  = skid_valid_r;
  assign take      = in_valid && !skid_valid_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || take;
      skid_valid_r <= 1'b0;
    end else if (take) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : in_data;
    end else if (take) begin
      skid_data_r <= in_data;
    end
  end

endmodule

// ===== rtl/core/one_wire_voice_command_transmitter_top.sv =====
`timescale 1ns / 1ps

// One-wire voice command transmitter. Every input transfer is one line tick
// (about 10 us) and yields exactly one result transfer: the line level for
// that tick, a busy flag and a rejected flag. One item is taken per clock
// cycle unless the output buffer stalls it; the result is registered in a
// two-entry output buffer, so input keeps flowing while one result waits.
// Commands arriving while a sequence is being sent are dropped and flagged.
// Configuration writes are applied in the cycle after cfg_we.

`include "assert_macros.svh"

module one_wire_voice_command_transmitter_top #(
  parameter int TIMER_WIDTH = omvct_pkg::TIMER_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic        [2:0] in_operation,
  input  logic        [7:0] in_track,
  input  logic              in_loop_single,
  input  logic signed [7:0] in_volume,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_line_level,
  output logic              out_busy_res,
  output logic              out_rejected,
  input  logic              cfg_we,
  input  logic        [2:0] cfg_index,
  input  logic       [15:0] cfg_wdata
);

  omvct_pkg::cfg_t cfg_r;
  omvct_pkg::cmd_t cmd;
  omvct_pkg::res_t res, res_out;
  logic            busy, step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_play <= 1'b1;
      cfg_r.start_high  <= omvct_pkg::RST_START_HIGH;
      cfg_r.start_low   <= omvct_pkg::RST_START_LOW;
      cfg_r.long_ticks  <= omvct_pkg::RST_LONG;
      cfg_r.short_ticks <= omvct_pkg::RST_SHORT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        omvct_pkg::CFG_ENABLE_PLAY: cfg_r.enable_play <= cfg_wdata[0];
        omvct_pkg::CFG_START_HIGH:  cfg_r.start_high  <= cfg_wdata;
        omvct_pkg::CFG_START_LOW:   cfg_r.start_low   <= cfg_wdata;
        omvct_pkg::CFG_LONG:        cfg_r.long_ticks  <= cfg_wdata;
        omvct_pkg::CFG_SHORT:       cfg_r.short_ticks <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign step = in_valid && !in_stall;

  omvct_cmd u_cmd (
    .operation   (in_operation),
    .track       (in_track),
    .loop_single (in_loop_single),
    .volume      (in_volume),
    .enable_play (cfg_r.enable_play),
    .busy        (busy),
    .cmd         (cmd)
  );

  omvct_seq #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .busy       (busy),
    .line_level (res.line_level),
    .busy_res   (res.busy_res)
  );

  assign res.rejected = cmd.rejected;

  omvct_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (res_out)
  );

  assign out_line_level = res_out.line_level;
  assign out_busy_res   = res_out.busy_res;
  assign out_rejected   = res_out.rejected;

  `OMVCT_ASSERT(a_rej_busy, out_valid && out_rejected |-> out_busy_res, "rejected while idle")
  `OMVCT_ASSERT(a_idle_high, out_valid && !out_busy_res |-> out_line_level, "idle line not high")
  `OMVCT_ASSERT(a_stall_src, in_stall |-> $past(out_valid && out_stall), "stall without backpressure")
  `OMVCT_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid && !in_stall, "buffer not empty after reset")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int LIMIT = 200_000;

  typedef struct {
    logic [2:0]        op;
    logic [7:0]        track;
    logic              loop_single;
    logic signed [7:0] volume;
  } tick_item_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic        [2:0] in_operation = omvct_pkg::OP_TICK;
  logic        [7:0] in_track = 8'd0;
  logic              in_loop_single = 1'b0;
  logic signed [7:0] in_volume = 8'sd0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_line_level;
  logic              out_busy_res;
  logic              out_rejected;
  logic              cfg_we = 1'b0;
  logic        [2:0] cfg_index = omvct_pkg::CFG_ENABLE_PLAY;
  logic       [15:0] cfg_wdata = 16'd0;

  one_wire_voice_command_transmitter_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_track       (in_track),
    .in_loop_single (in_loop_single),
    .in_volume      (in_volume),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_line_level (out_line_level),
    .out_busy_res   (out_busy_res),
    .out_rejected   (out_rejected),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // line predictor: configuration and sequencer state
  logic              play_en;
  logic [15:0]       start_high_t, start_low_t, long_t, short_t;
  logic [7:0]        seq_bytes [4];
  logic [2:0]        seq_total;
  logic [1:0]        seq_pos;
  logic [2:0]        bit_idx;
  omvct_pkg::phase_t ph;
  logic [15:0]       ticks_left;
  logic [7:0]        shift_reg;

  tick_item_t      pending_ticks[$];
  omvct_pkg::res_t line_q[$];
  tick_item_t      cur_tick;
  int              gap_pct = 0;
  int              in_gap = 0;
  int              out_gap = 0;
  int              errors = 0;
  int              cycles = 0;

  function automatic logic [15:0] ticks_of(logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic void load_byte();
    shift_reg  = seq_bytes[seq_pos];
    bit_idx    = 3'd0;
    ph         = omvct_pkg::PH_START_HIGH;
    ticks_left = ticks_of(start_high_t);
  endfunction

  function automatic void next_phase();
    case (ph)
      omvct_pkg::PH_START_HIGH: begin
        ph         = omvct_pkg::PH_START_LOW;
        ticks_left = ticks_of(start_low_t);
      end
      omvct_pkg::PH_START_LOW: begin
        ph         = omvct_pkg::PH_BIT_HIGH;
        bit_idx    = 3'd0;
        ticks_left = ticks_of(shift_reg[0] ? long_t : short_t);
      end
      omvct_pkg::PH_BIT_HIGH: begin
        ph         = omvct_pkg::PH_BIT_LOW;
        ticks_left = ticks_of(shift_reg[0] ? short_t : long_t);
      end
      default: begin
        shift_reg = shift_reg >> 1;
        if (bit_idx < 3'd7) begin
          bit_idx    = bit_idx + 3'd1;
          ph         = omvct_pkg::PH_BIT_HIGH;
          ticks_left = ticks_of(shift_reg[0] ? long_t : short_t);
        end else begin
          bit_idx = 3'd0;
          if (int'(seq_pos) + 1 >= int'(seq_total)) begin
            seq_pos    = 2'd0;
            ph         = omvct_pkg::PH_IDLE;
            ticks_left = 16'd0;
          end else begin
            seq_pos = seq_pos + 2'd1;
            load_byte();
          end
        end
      end
    endcase
  endfunction

  function automatic void step_line(tick_item_t t);
    logic [2:0]      op;
    logic [7:0]      q [4];
    int              n;
    int              v;
    omvct_pkg::res_t r;
    op = t.op;
    n = 0;
    v = t.volume;
    q[0] = 8'd0; q[1] = 8'd0; q[2] = 8'd0; q[3] = 8'd0;
    r.rejected = 1'b0;
    if (op == omvct_pkg::OP_PLAY && !play_en) op = omvct_pkg::OP_TICK;
    if (op >= omvct_pkg::OP_PLAY && op <= omvct_pkg::OP_VOLUME) begin
      if (ph != omvct_pkg::PH_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        case (op)
          omvct_pkg::OP_PLAY: begin
            q[n] = omvct_pkg::BYTE_PREFIX; n++;
            if (t.track >= 8'd10) begin
              q[n] = t.track / 8'd10; n++;
              q[n] = t.track % 8'd10; n++;
            end else begin
              q[n] = t.track; n++;
            end
            q[n] = omvct_pkg::BYTE_PLAY_END; n++;
          end
          omvct_pkg::OP_STOP: begin
            q[n] = omvct_pkg::BYTE_STOP; n++;
          end
          omvct_pkg::OP_LOOP: begin
            q[n] = omvct_pkg::BYTE_PREFIX; n++;
            q[n] = t.loop_single ? omvct_pkg::LOOP_SINGLE : omvct_pkg::LOOP_OTHER; n++;
            q[n] = omvct_pkg::BYTE_LOOP_END; n++;
          end
          default: begin
            if (v > int'(omvct_pkg::VOLUME_MAX)) v = int'(omvct_pkg::VOLUME_MAX);
            if (v < 0) v = 0;
            q[n] = omvct_pkg::BYTE_PREFIX; n++;
            q[n] = 8'(v / 10); n++;
            q[n] = 8'(v % 10); n++;
            q[n] = omvct_pkg::BYTE_VOL_END; n++;
          end
        endcase
        for (int i = 0; i < 4; i++) seq_bytes[i] = q[i];
        seq_total = 3'(n);
        seq_pos   = 2'd0;
        load_byte();
      end
    end
    if (ph == omvct_pkg::PH_IDLE) begin
      r.line_level = 1'b1;
      r.busy_res   = 1'b0;
    end else begin
      r.line_level = (ph == omvct_pkg::PH_START_HIGH || ph == omvct_pkg::PH_BIT_HIGH);
      r.busy_res   = 1'b1;
      if (ticks_left > 16'd0) ticks_left = ticks_left - 16'd1;
      if (ticks_left == 16'd0) next_phase();
    end
    line_q.push_back(r);
  endfunction

  function automatic tick_item_t make_tick(logic [2:0] op, logic [7:0] trk, logic lp,
                                           logic [7:0] vol);
    tick_item_t t;
    t.op          = op;
    t.track       = trk;
    t.loop_single = lp;
    t.volume      = vol;
    return t;
  endfunction

  function automatic tick_item_t rand_tick(int cmd_pct);
    tick_item_t t;
    if ($urandom_range(0, 99) < cmd_pct) t.op = 3'($urandom_range(1, 4));
    else if ($urandom_range(0, 3) == 0) t.op = 3'($urandom_range(5, 7));
    else t.op = omvct_pkg::OP_TICK;
    t.track       = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 9)) : 8'($urandom);
    t.loop_single = 1'($urandom);
    t.volume      = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 31)) : 8'($urandom);
    return t;
  endfunction

  task automatic report_mismatch(string what, logic exp_v, logic got_v);
    $display("[%0t] mismatch on %s: expected %0b, got %0b", $realtime, what, exp_v, got_v);
    errors++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      omvct_pkg::CFG_ENABLE_PLAY: play_en = val[0];
      omvct_pkg::CFG_START_HIGH:  start_high_t = val;
      omvct_pkg::CFG_START_LOW:   start_low_t = val;
      omvct_pkg::CFG_LONG:        long_t = val;
      default:                    short_t = val;
    endcase
  endtask

  task automatic write_all(logic en, logic [15:0] sh, logic [15:0] sl, logic [15:0] lg,
                           logic [15:0] st);
    write_reg(omvct_pkg::CFG_ENABLE_PLAY, {15'd0, en});
    write_reg(omvct_pkg::CFG_START_HIGH, sh);
    write_reg(omvct_pkg::CFG_START_LOW, sl);
    write_reg(omvct_pkg::CFG_LONG, lg);
    write_reg(omvct_pkg::CFG_SHORT, st);
    repeat (2) @(posedge clk);
  endtask

  // wait until every queued item is sent and every result is in
  task automatic wait_results();
    @(negedge clk);
    while (pending_ticks.size() != 0 || in_valid || line_q.size() != 0) @(negedge clk);
  endtask

  // keep the line ticking until the current sequence has gone out and all results are in
  task automatic drain_line();
    @(negedge clk);
    while (!(pending_ticks.size() == 0 && !in_valid && line_q.size() == 0 &&
             ph == omvct_pkg::PH_IDLE)) begin
      if (pending_ticks.size() == 0 && ph != omvct_pkg::PH_IDLE)
        pending_ticks.push_back(rand_tick(0));
      @(negedge clk);
    end
  endtask

  task automatic run_command(tick_item_t t);
    pending_ticks.push_back(t);
    drain_line();
  endtask

  // input driver
  always @(posedge clk) begin
    logic accepted;
    accepted = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid     <= 1'b0;
      play_en      = 1'b1;
      start_high_t = omvct_pkg::RST_START_HIGH;
      start_low_t  = omvct_pkg::RST_START_LOW;
      long_t       = omvct_pkg::RST_LONG;
      short_t      = omvct_pkg::RST_SHORT;
      for (int i = 0; i < 4; i++) seq_bytes[i] = 8'd0;
      seq_total  = 3'd0;
      seq_pos    = 2'd0;
      bit_idx    = 3'd0;
      ph         = omvct_pkg::PH_IDLE;
      ticks_left = 16'd0;
      shift_reg  = 8'd0;
    end else begin
      if (accepted) step_line(cur_tick);
      if (!in_valid || accepted) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() > 0 && $urandom_range(0, 99) < gap_pct) begin
          in_gap = $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          cur_tick = pending_ticks.pop_front();
          in_valid       <= 1'b1;
          in_operation   <= cur_tick.op;
          in_track       <= cur_tick.track;
          in_loop_single <= cur_tick.loop_single;
          in_volume      <= cur_tick.volume;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    omvct_pkg::res_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (line_q.size() == 0) begin
          report_mismatch("unexpected result transfer", 1'b0, 1'b1);
        end else begin
          exp_r = line_q.pop_front();
          if (out_line_level !== exp_r.line_level)
            report_mismatch("line_level", exp_r.line_level, out_line_level);
          if (out_busy_res !== exp_r.busy_res)
            report_mismatch("busy_res", exp_r.busy_res, out_busy_res);
          if (out_rejected !== exp_r.rejected)
            report_mismatch("rejected", exp_r.rejected, out_rejected);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < gap_pct) begin
        out_gap = $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("** one_wire_voice_command_transmitter_top: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset timing
    gap_pct = 8;
    run_command(make_tick(omvct_pkg::OP_STOP, 8'd0, 1'b0, 8'd0));

    // every command and its boundary values
    write_all(1'b1, 16'd1, 16'd1, 16'd2, 16'd1);
    run_command(make_tick(omvct_pkg::OP_PLAY, 8'd9, 1'b1, 8'd0));
    run_command(make_tick(omvct_pkg::OP_PLAY, 8'd10, 1'b0, 8'd0));
    run_command(make_tick(omvct_pkg::OP_PLAY, 8'd255, 1'b1, 8'hff));
    run_command(make_tick(omvct_pkg::OP_LOOP, 8'd0, 1'b1, 8'd0));
    run_command(make_tick(omvct_pkg::OP_LOOP, 8'hff, 1'b0, 8'd0));
    run_command(make_tick(omvct_pkg::OP_VOLUME, 8'd0, 1'b0, 8'h80));
    run_command(make_tick(omvct_pkg::OP_VOLUME, 8'd0, 1'b0, 8'h7f));
    // unused opcodes only tick
    pending_ticks.push_back(make_tick(3'd5, 8'd12, 1'b1, 8'd7));
    pending_ticks.push_back(make_tick(3'd6, 8'd12, 1'b0, 8'd7));
    pending_ticks.push_back(make_tick(3'd7, 8'd12, 1'b1, 8'd7));
    // commands while busy are dropped
    pending_ticks.push_back(make_tick(omvct_pkg::OP_STOP, 8'd0, 1'b0, 8'd0));
    pending_ticks.push_back(make_tick(omvct_pkg::OP_PLAY, 8'd33, 1'b0, 8'd0));
    pending_ticks.push_back(make_tick(omvct_pkg::OP_LOOP, 8'd0, 1'b1, 8'd0));
    pending_ticks.push_back(make_tick(omvct_pkg::OP_VOLUME, 8'd0, 1'b0, 8'd9));
    run_command(make_tick(omvct_pkg::OP_STOP, 8'd0, 1'b0, 8'd0));

    // play disabled: ignored when idle and when busy
    write_reg(omvct_pkg::CFG_ENABLE_PLAY, 16'd0);
    repeat (2) @(posedge clk);
    run_command(make_tick(omvct_pkg::OP_PLAY, 8'd42, 1'b0, 8'd0));
    pending_ticks.push_back(make_tick(omvct_pkg::OP_STOP, 8'd0, 1'b0, 8'd0));
    run_command(make_tick(omvct_pkg::OP_PLAY, 8'd42, 1'b0, 8'd0));

    // zero durations count as one tick
    write_all(1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
    run_command(make_tick(omvct_pkg::OP_STOP, 8'd0, 1'b0, 8'd0));
    run_command(make_tick(omvct_pkg::OP_PLAY, 8'd99, 1'b0, 8'd0));

    // random traffic with short timings
    for (int p = 0; p < 4; p++) begin
      gap_pct = (p == 3) ? 0 : ((p == 1) ? 4 : 12);
      write_all((p == 0) ? 1'b1 : 1'($urandom), 16'($urandom_range(0, 2)),
                16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)),
                16'($urandom_range(0, 2)));
      for (int i = 0; i < 50; i++) begin
        pending_ticks.push_back(rand_tick(10));
        if (p == 1 && i == 25) begin
          wait_results();
        end
      end
      drain_line();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("** one_wire_voice_command_transmitter_top: PASSED **");
    end else begin
      $display("** one_wire_voice_command_transmitter_top: FAILED **");
    end
    $finish;
  end

endmodule
